/* src/tbpg_pkg.sv */
package tbpg_pkg;

    localparam int T_W        = 16;
    localparam int SAMP_W     = 10;
    localparam int PAUSE_W    = 22;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // one sample is 95 T-states; a pulse rounds (t + 36) / 95
    localparam int T_ROUND      = 36;
    localparam int T_PER_SAMPLE = 95;
    localparam int MS_SAMPLES   = (3500 + T_ROUND) / T_PER_SAMPLE;

    // reciprocal of 95, exact for every dividend t + 36 with a 16-bit t
    localparam int RECIP_SHIFT = 23;
    localparam int RECIP       = (2 ** RECIP_SHIFT + T_PER_SAMPLE - 1) / T_PER_SAMPLE;

    localparam logic [3:0] BYTE_BITS = 4'd8;

    // register reset values
    localparam logic [T_W-1:0] PILOT_T_RST     = 16'd2168;
    localparam logic [T_W-1:0] SYNC_FIRST_RST  = 16'd667;
    localparam logic [T_W-1:0] SYNC_SECOND_RST = 16'd735;
    localparam logic [T_W-1:0] ZERO_BIT_RST    = 16'd855;
    localparam logic [T_W-1:0] ONE_BIT_RST     = 16'd1710;
    localparam logic [T_W-1:0] PILOT_COUNT_RST = 16'd8064;
    localparam logic [3:0]     LAST_BITS_RST   = 4'd8;
    localparam logic [T_W-1:0] PAUSE_MS_RST    = 16'd1000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PILOT_T     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_BIT    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_BIT     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PILOT_COUNT = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_BITS   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_MS    = 4'd7;

    // request commands
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_PULSE = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    // block kinds
    localparam logic [2:0] KIND_STANDARD = 3'd0;
    localparam logic [2:0] KIND_TONE     = 3'd1;
    localparam logic [2:0] KIND_DATA     = 3'd2;
    localparam logic [2:0] KIND_PULSES   = 3'd3;
    localparam logic [2:0] KIND_PAUSE    = 3'd4;

    // generator phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_TONE   = 3'd1;
    localparam logic [2:0] PH_PILOT  = 3'd2;
    localparam logic [2:0] PH_SYNC   = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_TRAIL  = 3'd5;
    localparam logic [2:0] PH_PAUSE  = 3'd6;
    localparam logic [2:0] PH_PULSES = 3'd7;

    // pulse lengths are kept as sample counts
    typedef struct packed {
        logic [SAMP_W-1:0]  pilot_n;
        logic [SAMP_W-1:0]  sync1_n;
        logic [SAMP_W-1:0]  sync2_n;
        logic [SAMP_W-1:0]  zero_n;
        logic [SAMP_W-1:0]  one_n;
        logic [T_W-1:0]     pilot_count;
        logic [3:0]         last_byte_bits;
        logic [T_W-1:0]     pause_ms;
        logic [PAUSE_W-1:0] pause_samples;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [2:0]        block_kind;
        logic [7:0]        data_byte;
        logic              last_byte;
        logic [SAMP_W-1:0] pulse_n;
    } item_t;

    function automatic logic [SAMP_W-1:0] samples_of(input logic [T_W-1:0] t);
        logic [T_W:0]       x;
        logic [2*T_W+1:0]   p;
        x = {1'b0, t} + (T_W + 1)'(T_ROUND);
        p = {(T_W + 1)'(0), x} * (2 * T_W + 2)'(RECIP);
        return p[RECIP_SHIFT +: SAMP_W];
    endfunction

    function automatic logic [PAUSE_W-1:0] pause_samples_of(input logic [T_W-1:0] ms);
        logic [PAUSE_W-1:0] x;
        x = PAUSE_W'(ms);
        return x * PAUSE_W'(MS_SAMPLES);
    endfunction

endpackage

/* src/tbpg_cfg.sv */
module tbpg_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tbpg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tbpg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output tbpg_pkg::cfg_t                      cfg
);

    tbpg_pkg::cfg_t                      cfg_reg;
    logic [tbpg_pkg::SAMP_W-1:0]         wr_samples;
    logic [tbpg_pkg::PAUSE_W-1:0]        wr_pause;

    // convert T-states to samples once, at write time
    assign wr_samples = tbpg_pkg::samples_of(cfg_wdata);
    assign wr_pause   = tbpg_pkg::pause_samples_of(cfg_wdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pilot_n        <= tbpg_pkg::samples_of(tbpg_pkg::PILOT_T_RST);
            cfg_reg.sync1_n        <= tbpg_pkg::samples_of(tbpg_pkg::SYNC_FIRST_RST);
            cfg_reg.sync2_n        <= tbpg_pkg::samples_of(tbpg_pkg::SYNC_SECOND_RST);
            cfg_reg.zero_n         <= tbpg_pkg::samples_of(tbpg_pkg::ZERO_BIT_RST);
            cfg_reg.one_n          <= tbpg_pkg::samples_of(tbpg_pkg::ONE_BIT_RST);
            cfg_reg.pilot_count    <= tbpg_pkg::PILOT_COUNT_RST;
            cfg_reg.last_byte_bits <= tbpg_pkg::LAST_BITS_RST;
            cfg_reg.pause_ms       <= tbpg_pkg::PAUSE_MS_RST;
            cfg_reg.pause_samples  <= tbpg_pkg::pause_samples_of(tbpg_pkg::PAUSE_MS_RST);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tbpg_pkg::REG_PILOT_T:     cfg_reg.pilot_n <= wr_samples;
                tbpg_pkg::REG_SYNC_FIRST:  cfg_reg.sync1_n <= wr_samples;
                tbpg_pkg::REG_SYNC_SECOND: cfg_reg.sync2_n <= wr_samples;
                tbpg_pkg::REG_ZERO_BIT:    cfg_reg.zero_n  <= wr_samples;
                tbpg_pkg::REG_ONE_BIT:     cfg_reg.one_n   <= wr_samples;
                tbpg_pkg::REG_PILOT_COUNT: cfg_reg.pilot_count <= cfg_wdata;
                tbpg_pkg::REG_LAST_BITS:   cfg_reg.last_byte_bits <= cfg_wdata[3:0];
                tbpg_pkg::REG_PAUSE_MS: begin
                    cfg_reg.pause_ms      <= cfg_wdata;
                    cfg_reg.pause_samples <= wr_pause;
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/tbpg_ingress.sv */
module tbpg_ingress (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_cmd,
    input  logic [2:0]                  s_block_kind,
    input  logic [7:0]                  s_data_byte,
    input  logic                        s_last_byte,
    input  logic [tbpg_pkg::T_W-1:0]    s_pulse_t,
    input  logic                        advance,
    output logic                        item_valid,
    output tbpg_pkg::item_t             item
);

    logic            valid_reg;
    tbpg_pkg::item_t item_reg;
    logic            take;

    assign s_ready = !valid_reg || advance;
    assign take    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    // pulse length is turned into samples before it is registered
    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg.cmd        <= s_cmd;
            item_reg.block_kind <= s_block_kind;
            item_reg.data_byte  <= s_data_byte;
            item_reg.last_byte  <= s_last_byte;
            item_reg.pulse_n    <= tbpg_pkg::samples_of(s_pulse_t);
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* src/tbpg_engine.sv */
module tbpg_engine (
    input  logic            aclk,
    input  logic            aresetn,
    input  tbpg_pkg::cfg_t  cfg,
    input  logic            item_valid,
    input  tbpg_pkg::item_t item,
    output logic            item_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_sample_valid,
    output logic            m_sample_level,
    output logic            m_need_input,
    output logic            m_block_done
);

    typedef struct packed {
        logic [2:0]                     phase;
        logic                           level;
        logic [tbpg_pkg::T_W-1:0]       pulses_left;
        logic [tbpg_pkg::SAMP_W-1:0]    samples_left;
        logic                           second_half;
        logic [7:0]                     shift_byte;
        logic [3:0]                     bits_left;
        logic                           byte_is_last;
        logic [tbpg_pkg::PAUSE_W-1:0]   pause_left;
    } st_t;

    st_t  state_reg;
    st_t  state_next;
    logic m_valid_reg;
    logic smp_valid;
    logic smp_level;
    logic need_input;
    logic fire;

    function automatic st_t enter_pause(input st_t s, input tbpg_pkg::cfg_t c);
        st_t r;
        r = s;
        if (c.pause_ms == '0) begin
            r.phase = tbpg_pkg::PH_IDLE;
        end else begin
            r.level      = 1'b0;
            r.pause_left = c.pause_samples;
            r.phase      = tbpg_pkg::PH_PAUSE;
        end
        return r;
    endfunction

    function automatic st_t enter_data(input st_t s);
        st_t r;
        r = s;
        r.phase        = tbpg_pkg::PH_DATA;
        r.bits_left    = '0;
        r.byte_is_last = 1'b0;
        r.second_half  = 1'b0;
        r.samples_left = '0;
        return r;
    endfunction

    function automatic st_t end_data(input st_t s, input tbpg_pkg::cfg_t c);
        st_t r;
        r = s;
        if (r.level && c.pause_ms != '0) begin
            r.phase       = tbpg_pkg::PH_TRAIL;
            r.second_half = 1'b0;
        end else begin
            r = enter_pause(r, c);
        end
        return r;
    endfunction

    // current pulse fully sent
    function automatic st_t pulse_done(input st_t s, input tbpg_pkg::cfg_t c);
        st_t r;
        r = s;
        case (r.phase)
            tbpg_pkg::PH_TONE, tbpg_pkg::PH_PILOT: begin
                r.level = !r.level;
                if (r.pulses_left != '0) r.pulses_left = r.pulses_left - 1'b1;
            end
            tbpg_pkg::PH_SYNC: begin
                r.level = !r.level;
                if (!r.second_half) r.second_half = 1'b1;
                else r = enter_data(r);
            end
            tbpg_pkg::PH_DATA: begin
                r.level = !r.level;
                if (!r.second_half) begin
                    r.second_half = 1'b1;
                end else begin
                    r.second_half = 1'b0;
                    r.shift_byte  = r.shift_byte << 1;
                    if (r.bits_left != '0) r.bits_left = r.bits_left - 1'b1;
                end
            end
            tbpg_pkg::PH_TRAIL: begin
                if (!r.second_half) begin
                    r.second_half = 1'b1;
                end else begin
                    r.second_half = 1'b0;
                    r = enter_pause(r, c);
                end
            end
            tbpg_pkg::PH_PULSES: begin
                r.level = !r.level;
                if (r.byte_is_last) r.phase = tbpg_pkg::PH_IDLE;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Walk the phases in block order until a pulse with samples is loaded,
    // input is awaited, or the block ends. Zero-length pulses are skipped
    // in closed form: a run of pilot pulses flips the level by its parity,
    // a skipped data bit flips it twice.
    function automatic st_t settle(input st_t s, input tbpg_pkg::cfg_t c);
        st_t        r;
        logic [3:0] k;
        logic       found;
        logic       bit_zero;
        r = s;
        k = '0;
        found = 1'b0;
        bit_zero = 1'b0;

        if (r.samples_left == '0 &&
            (r.phase == tbpg_pkg::PH_TONE || r.phase == tbpg_pkg::PH_PILOT)) begin
            if (r.pulses_left != '0 && c.pilot_n != '0) begin
                r.samples_left = c.pilot_n;
            end else begin
                r.level       = r.level ^ r.pulses_left[0];
                r.pulses_left = '0;
                if (r.phase == tbpg_pkg::PH_TONE) begin
                    r.phase = tbpg_pkg::PH_IDLE;
                end else begin
                    r.phase       = tbpg_pkg::PH_SYNC;
                    r.second_half = 1'b0;
                end
            end
        end

        if (r.samples_left == '0 && r.phase == tbpg_pkg::PH_SYNC && !r.second_half) begin
            if (c.sync1_n != '0) begin
                r.samples_left = c.sync1_n;
            end else begin
                r.level       = !r.level;
                r.second_half = 1'b1;
            end
        end
        if (r.samples_left == '0 && r.phase == tbpg_pkg::PH_SYNC && r.second_half) begin
            if (c.sync2_n != '0) begin
                r.samples_left = c.sync2_n;
            end else begin
                r.level = !r.level;
                r = enter_data(r);
            end
        end

        // second half of a bit still pending
        if (r.samples_left == '0 && r.phase == tbpg_pkg::PH_DATA &&
            r.bits_left != '0 && r.second_half) begin
            if ((r.shift_byte[7] ? c.one_n : c.zero_n) != '0) begin
                r.samples_left = r.shift_byte[7] ? c.one_n : c.zero_n;
            end else begin
                r.level       = !r.level;
                r.second_half = 1'b0;
                r.shift_byte  = r.shift_byte << 1;
                r.bits_left   = r.bits_left - 1'b1;
            end
        end

        // skip leading zero-length bits, then load the first audible one
        if (r.samples_left == '0 && r.phase == tbpg_pkg::PH_DATA &&
            (!r.second_half || r.bits_left == '0)) begin
            k = r.bits_left;
            for (int i = 0; i < 8; i++) begin
                bit_zero = r.shift_byte[3'(7 - i)] ? (c.one_n == '0) : (c.zero_n == '0);
                if (!found && 4'(i) < r.bits_left && !bit_zero) begin
                    k = 4'(i);
                    found = 1'b1;
                end
            end
            r.shift_byte = r.shift_byte << k;
            r.bits_left  = r.bits_left - k;
            if (r.bits_left != '0) begin
                r.samples_left = r.shift_byte[7] ? c.one_n : c.zero_n;
            end else if (r.byte_is_last) begin
                r = end_data(r, c);
            end
        end

        if (r.samples_left == '0 && r.phase == tbpg_pkg::PH_TRAIL && !r.second_half) begin
            if (c.zero_n != '0) r.samples_left = c.zero_n;
            else r.second_half = 1'b1;
        end
        if (r.samples_left == '0 && r.phase == tbpg_pkg::PH_TRAIL && r.second_half) begin
            if (c.one_n != '0) begin
                r.samples_left = c.one_n;
            end else begin
                r.second_half = 1'b0;
                r = enter_pause(r, c);
            end
        end

        if (r.samples_left == '0 && r.phase == tbpg_pkg::PH_PAUSE && r.pause_left == '0) begin
            r.phase = tbpg_pkg::PH_IDLE;
        end
        return r;
    endfunction

    always_comb begin
        state_next = state_reg;
        smp_valid  = 1'b0;
        smp_level  = 1'b0;
        case (item.cmd)
            tbpg_pkg::CMD_START: begin
                if (item.block_kind <= tbpg_pkg::KIND_PAUSE) begin
                    state_next.samples_left = '0;
                    state_next.second_half  = 1'b0;
                    state_next.bits_left    = '0;
                    state_next.byte_is_last = 1'b0;
                    state_next.pause_left   = '0;
                    state_next.pulses_left  = '0;
                    case (item.block_kind)
                        tbpg_pkg::KIND_STANDARD: begin
                            state_next.phase       = tbpg_pkg::PH_PILOT;
                            state_next.pulses_left = cfg.pilot_count;
                        end
                        tbpg_pkg::KIND_TONE: begin
                            state_next.phase       = tbpg_pkg::PH_TONE;
                            state_next.pulses_left = cfg.pilot_count;
                        end
                        tbpg_pkg::KIND_DATA:   state_next = enter_data(state_next);
                        tbpg_pkg::KIND_PULSES: state_next.phase = tbpg_pkg::PH_PULSES;
                        default:               state_next = enter_pause(state_next, cfg);
                    endcase
                    state_next = settle(state_next, cfg);
                end
            end
            tbpg_pkg::CMD_DATA: begin
                if (state_reg.phase == tbpg_pkg::PH_DATA && state_reg.samples_left == '0 &&
                    state_reg.bits_left == '0 && !state_reg.byte_is_last) begin
                    state_next.shift_byte   = item.data_byte;
                    state_next.byte_is_last = item.last_byte;
                    if (!item.last_byte) begin
                        state_next.bits_left = tbpg_pkg::BYTE_BITS;
                    end else if (cfg.last_byte_bits > tbpg_pkg::BYTE_BITS) begin
                        state_next.bits_left = tbpg_pkg::BYTE_BITS;
                    end else begin
                        state_next.bits_left = cfg.last_byte_bits;
                    end
                    state_next.second_half = 1'b0;
                    state_next = settle(state_next, cfg);
                end
            end
            tbpg_pkg::CMD_PULSE: begin
                if (state_reg.phase == tbpg_pkg::PH_PULSES && state_reg.samples_left == '0) begin
                    state_next.byte_is_last = item.last_byte;
                    if (item.pulse_n != '0) state_next.samples_left = item.pulse_n;
                    else state_next = pulse_done(state_next, cfg);
                    state_next = settle(state_next, cfg);
                end
            end
            tbpg_pkg::CMD_TICK: begin
                if (state_reg.samples_left != '0) begin
                    smp_valid = 1'b1;
                    smp_level = state_reg.level;
                    state_next.samples_left = state_reg.samples_left - 1'b1;
                    if (state_next.samples_left == '0) begin
                        state_next = pulse_done(state_next, cfg);
                        state_next = settle(state_next, cfg);
                    end
                end else if (state_reg.phase == tbpg_pkg::PH_PAUSE &&
                             state_reg.pause_left != '0) begin
                    smp_valid = 1'b1;
                    state_next.pause_left = state_reg.pause_left - 1'b1;
                    if (state_next.pause_left == '0) state_next.phase = tbpg_pkg::PH_IDLE;
                end
            end
        endcase
    end

    assign need_input =
        (state_next.phase == tbpg_pkg::PH_DATA && state_next.samples_left == '0 &&
         state_next.bits_left == '0 && !state_next.byte_is_last) ||
        (state_next.phase == tbpg_pkg::PH_PULSES && state_next.samples_left == '0);

    assign item_ready = !m_valid_reg || m_ready;
    assign fire       = item_valid && item_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg            <= 1'b0;
            state_reg.phase        <= tbpg_pkg::PH_IDLE;
            state_reg.level        <= 1'b0;
            state_reg.pulses_left  <= '0;
            state_reg.samples_left <= '0;
            state_reg.second_half  <= 1'b0;
            state_reg.bits_left    <= '0;
            state_reg.byte_is_last <= 1'b0;
            state_reg.pause_left   <= '0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
            state_reg   <= state_next;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_sample_valid <= smp_valid;
            m_sample_level <= smp_level;
            m_need_input   <= need_input;
            m_block_done   <= (state_next.phase == tbpg_pkg::PH_IDLE);
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* src/tape_block_pulse_generator.sv */
// Tape block pulse generator: plays tape blocks as a one-bit signal, one
// sample per tick request.
// Requests come in on s_valid/s_ready: s_cmd selects start block (with
// s_block_kind), data byte (s_data_byte, s_last_byte marks the final one),
// pulse length (s_pulse_t, s_last_byte marks the final pulse) or sample tick.
// Every request gives exactly one result on m_valid/m_ready: m_sample_valid
// and m_sample_level for a tick, m_need_input when the generator waits for
// a data byte or pulse length, m_block_done when no block is in progress.
// Block parameters are written on cfg_wr_en/cfg_index/cfg_wdata; the user must
// write them only while the block is idle, which the block does not enforce;
// pulse lengths are converted to samples as they are written. An accepted
// request waits in the request register, then its result in the result register.
// Throughput: one request per cycle while m_ready is high; the pacing path is
// the combinational state update (pulse sequencing and zero-length pulse skip)
// between the request register and the result register.
// Reset: idle, level low, no result pending; registers return to defaults.
// When m_ready is low the result holds and one more request is still taken
// into the request register; s_ready drops only when both are full.
module tape_block_pulse_generator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tbpg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tbpg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_cmd,
    input  logic [2:0]                          s_block_kind,
    input  logic [7:0]                          s_data_byte,
    input  logic                                s_last_byte,
    input  logic [tbpg_pkg::T_W-1:0]            s_pulse_t,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_sample_valid,
    output logic                                m_sample_level,
    output logic                                m_need_input,
    output logic                                m_block_done
);

    tbpg_pkg::cfg_t  cfg;
    tbpg_pkg::item_t item;
    logic            item_valid;
    logic            item_ready;

    tbpg_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tbpg_ingress u_ingress (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_block_kind (s_block_kind),
        .s_data_byte  (s_data_byte),
        .s_last_byte  (s_last_byte),
        .s_pulse_t    (s_pulse_t),
        .advance      (item_ready),
        .item_valid   (item_valid),
        .item         (item)
    );

    tbpg_engine u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .item_valid     (item_valid),
        .item           (item),
        .item_ready     (item_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_valid (m_sample_valid),
        .m_sample_level (m_sample_level),
        .m_need_input   (m_need_input),
        .m_block_done   (m_block_done)
    );

    // a high sample only comes out of a tick that produced one
    a_level_needs_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sample_level |-> m_sample_valid)
        else $error("high level reported without a sample");

    // an idle generator never waits for input
    a_done_not_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_need_input && m_block_done))
        else $error("block done while input is awaited");

    // reset empties the result stage
    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending right after reset");

    // with the request register empty, a request is always taken
    a_empty_takes_request: assert property (@(posedge aclk) disable iff (!aresetn)
        !item_valid |-> s_ready)
        else $error("request refused with empty request register");

endmodule
